FILE: sv/cjpm_pkg.sv
// ----------------------------------------------------------------------------
// cjpm_pkg
// Shared types and constants of the coupled joint polynomial map: number
// formats, register indexes, and the token that travels down the cell chain.
// ----------------------------------------------------------------------------
package cjpm_pkg;

    // Coefficients in the packed register; also the number of chain cells
    // (MAX_COEFFS - 1 Horner steps and one closing multiply-add step).
    localparam int MAX_COEFFS = 4;
    localparam int CELL_COUNT = MAX_COEFFS;

    localparam int VALUE_W = 16;                 // Q3.12 port values
    localparam int COUNT_W = 3;                  // coeff_count register
    localparam int PACK_W  = 64;                 // coeff_pack register
    localparam int FRAC_W  = 12;
    localparam int ROUND   = 1 << (FRAC_W - 1);  // round half up
    localparam int WIDE_W  = 41;                 // [-2^40, 2^40 - 1]
    localparam int X_W     = VALUE_W + 1;        // difference of two angles
    localparam int ADD_W   = VALUE_W + 2;        // up to 3 * coefficient
    localparam int PROD_W  = WIDE_W + X_W;       // acc * x + ROUND
    localparam int CFG_W   = PACK_W;
    localparam int INDEX_W = 3;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [INDEX_W-1:0] {
        REG_MASTER_INIT,
        REG_MASTER_MIN,
        REG_MASTER_MAX,
        REG_SLAVE_INIT,
        REG_SLAVE_MIN,
        REG_SLAVE_MAX,
        REG_COEFF_COUNT,
        REG_COEFF_PACK
    } cfg_index_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] master_init;
        logic signed [VALUE_W-1:0] master_min;
        logic signed [VALUE_W-1:0] master_max;
        logic signed [VALUE_W-1:0] slave_init;
        logic signed [VALUE_W-1:0] slave_min;
        logic signed [VALUE_W-1:0] slave_max;
        logic [COUNT_W-1:0]        coeff_count;
        logic [PACK_W-1:0]         coeff_pack;
    } cfg_t;

    // One multiply-add step: acc <= addend +/- qmul(acc, operand), or
    // acc <= addend + acc when bypass is set.
    typedef struct packed {
        logic signed [ADD_W-1:0] addend;
        logic signed [X_W-1:0]   operand;
        logic                    sub;
        logic                    bypass;
    } step_t;

    // Work item; steps[0] is consumed by the next cell, the rest shift down.
    typedef struct packed {
        logic signed [WIDE_W-1:0]   acc;
        step_t [CELL_COUNT-1:0]     steps;
        logic                       sat;
    } token_t;

endpackage

FILE: sv/cjpm_prep.sv
// ----------------------------------------------------------------------------
// cjpm_prep
// Front stage: range check, clipping, coefficient layout and step program
// for one request, registered into a chain token.
// ----------------------------------------------------------------------------
module cjpm_prep
    import cjpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic signed [VALUE_W-1:0] master_angle,
    input  logic signed [VALUE_W-1:0] master_velocity,
    output logic                      out_valid,
    input  logic                      out_ready,
    output token_t                    out_tok
);

    logic                    valid_reg;
    token_t                  tok_reg;
    token_t                  tok_next;

    logic [COUNT_W-1:0]      n_eff;
    logic                    linear;
    logic                    below;
    logic                    above;
    logic                    use_poly;
    logic                    use_deriv;
    logic signed [VALUE_W-1:0] clip;
    logic signed [X_W-1:0]   x_horner;
    logic signed [X_W-1:0]   x_final;
    logic signed [ADD_W-1:0] addend_final;
    logic signed [ADD_W-1:0] coef_ext [MAX_COEFFS];
    logic signed [ADD_W-1:0] k_vec [MAX_COEFFS];

    always_comb
    begin
        n_eff = cfg.coeff_count;
        if (n_eff == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (n_eff > COUNT_W'(MAX_COEFFS))
        begin
            n_eff = COUNT_W'(MAX_COEFFS);
        end
        linear = (n_eff == COUNT_W'(1));
    end

    // Lower limit first: it wins when the limits cross.
    assign below = (master_angle < cfg.master_min);
    assign above = !below && (master_angle > cfg.master_max);
    assign clip  = below ? cfg.master_min : (above ? cfg.master_max : master_angle);

    assign x_horner  = X_W'(clip) - X_W'(cfg.master_init);
    assign use_poly  = linear || (!req_type && !below && !above);
    assign use_deriv = !use_poly;

    // Closing step operand and base.
    always_comb
    begin
        x_final      = '0;
        addend_final = '0;
        if (req_type)
        begin
            x_final = X_W'(master_velocity);
        end
        else if (linear)
        begin
            x_final      = X_W'(master_angle) - X_W'(cfg.master_init);
            addend_final = ADD_W'(cfg.slave_init);
        end
        else if (below)
        begin
            x_final      = X_W'(cfg.master_min) - X_W'(master_angle);
            addend_final = ADD_W'(cfg.slave_min);
        end
        else if (above)
        begin
            x_final      = X_W'(master_angle) - X_W'(cfg.master_max);
            addend_final = ADD_W'(cfg.slave_max);
        end
        else
        begin
            addend_final = ADD_W'(cfg.slave_init);
        end
    end

    // Coefficients right-aligned so that leading zero steps are harmless.
    // Derivative terms carry their power as a small constant factor.
    always_comb
    begin
        for (int j = 0; j < MAX_COEFFS; j++)
        begin
            coef_ext[j] = ADD_W'(signed'(cfg.coeff_pack[VALUE_W*j +: VALUE_W]));
        end
        for (int t = 0; t < MAX_COEFFS; t++)
        begin
            k_vec[t] = '0;
            for (int j = 0; j < MAX_COEFFS; j++)
            begin
                if (use_poly && (j + MAX_COEFFS == t + int'(n_eff)))
                begin
                    k_vec[t] = coef_ext[j];
                end
                if (use_deriv && (j + MAX_COEFFS + 1 == t + int'(n_eff)))
                begin
                    k_vec[t] = coef_ext[j] * signed'(ADD_W'(MAX_COEFFS - t));
                end
            end
        end
    end

    always_comb
    begin
        tok_next     = '0;
        tok_next.acc = WIDE_W'(k_vec[0]);
        for (int i = 0; i < CELL_COUNT - 1; i++)
        begin
            tok_next.steps[i].addend  = k_vec[i+1];
            tok_next.steps[i].operand = x_horner;
            tok_next.steps[i].sub     = 1'b0;
            tok_next.steps[i].bypass  = 1'b0;
        end
        tok_next.steps[CELL_COUNT-1].addend  = addend_final;
        tok_next.steps[CELL_COUNT-1].operand = x_final;
        tok_next.steps[CELL_COUNT-1].sub     = use_deriv && !req_type && below;
        tok_next.steps[CELL_COUNT-1].bypass  = use_poly && !linear;
        tok_next.sat = 1'b0;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

FILE: sv/cjpm_cell.sv
// ----------------------------------------------------------------------------
// cjpm_cell
// One multiply-add cell of the chain: registered Q.12 product with rounding
// offset, then shift, clamp, add and clamp into the next token. Two stages,
// each with its own valid bit so bubbles collapse.
// ----------------------------------------------------------------------------
module cjpm_cell
    import cjpm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_tok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    localparam int SH_W  = PROD_W - FRAC_W;
    localparam int SUM_W = WIDE_W + 1;

    // Stage A: product
    logic                     a_valid_reg;
    logic signed [PROD_W-1:0] a_prod_reg;
    logic signed [PROD_W-1:0] a_prod_next;
    token_t                   a_tok_reg;
    logic                     a_ready;
    logic signed [WIDE_W-1:0] acc_in;
    logic signed [X_W-1:0]    op_in;

    // Stage B: accumulate
    logic                     b_valid_reg;
    token_t                   b_tok_reg;
    token_t                   b_tok_next;
    logic                     b_ready;

    logic signed [SH_W-1:0]   q_sh;
    logic                     mul_fits;
    logic signed [WIDE_W-1:0] mul_clamped;
    logic signed [WIDE_W-1:0] term;
    logic signed [ADD_W-1:0]  addend;
    logic signed [SUM_W-1:0]  sum;
    logic                     sum_fits;
    step_t                    step;

    assign acc_in      = in_tok.acc;
    assign op_in       = in_tok.steps[0].operand;
    assign a_prod_next = PROD_W'(acc_in) * PROD_W'(op_in) + PROD_W'(ROUND);

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_prod_reg <= a_prod_next;
            a_tok_reg  <= in_tok;
        end
    end

    // Arithmetic shift is floor division by 4096.
    assign step   = a_tok_reg.steps[0];
    assign addend = step.addend;

    always_comb
    begin
        q_sh     = signed'(a_prod_reg[PROD_W-1:FRAC_W]);
        mul_fits = (q_sh[SH_W-1:WIDE_W-1] == {(SH_W-WIDE_W+1){q_sh[SH_W-1]}});
        if (mul_fits)
        begin
            mul_clamped = q_sh[WIDE_W-1:0];
        end
        else
        begin
            mul_clamped = q_sh[SH_W-1] ? WIDE_MIN : WIDE_MAX;
        end
        term = step.bypass ? a_tok_reg.acc : mul_clamped;
        if (step.sub)
        begin
            sum = SUM_W'(addend) - SUM_W'(term);
        end
        else
        begin
            sum = SUM_W'(addend) + SUM_W'(term);
        end
        sum_fits = (sum[SUM_W-1] == sum[WIDE_W-1]);

        b_tok_next = a_tok_reg;
        if (sum_fits)
        begin
            b_tok_next.acc = sum[WIDE_W-1:0];
        end
        else
        begin
            b_tok_next.acc = sum[SUM_W-1] ? WIDE_MIN : WIDE_MAX;
        end
        for (int i = 0; i < CELL_COUNT - 1; i++)
        begin
            b_tok_next.steps[i] = a_tok_reg.steps[i+1];
        end
        b_tok_next.steps[CELL_COUNT-1] = '0;
        b_tok_next.sat = a_tok_reg.sat || (!step.bypass && !mul_fits) || !sum_fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_tok_reg <= b_tok_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_tok   = b_tok_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_ready |=> a_valid_reg && $stable(a_prod_reg))
        else $error("cell product lost while stalled");

    sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_ready && a_tok_reg.sat |=> b_tok_reg.sat)
        else $error("saturation flag dropped inside cell");

endmodule

FILE: sv/coupled_joint_polynomial_map_core.sv
// ----------------------------------------------------------------------------
// coupled_joint_polynomial_map_core
// Maps a master joint angle or velocity to the coupled slave joint angle or
// velocity: linear or polynomial (Horner) map in saturating Q3.12, with
// tangent extension outside the master range.
//
//   channel   direction  handshake             payload
//   -------   ---------  --------------------  -------------------------------
//   req       in         req_valid/req_ready   req_type, master_angle,
//                                              master_velocity
//   rsp       out        rsp_valid/rsp_ready   slave_value, saturated
//   cfg       in         cfg_we (no wait)      cfg_index, cfg_data
//
// One transfer per cycle sustained while rsp_ready is held; a req transfer
// passes to rsp_valid through one front stage, two stages in each of the 4
// cells of the multiply-add chain (product register, accumulate register),
// and the output register. Every stage has its own valid bit, so bubbles
// close up and a req transfer is taken while a result waits at rsp. Reset
// (rst_n, async, low) empties the pipeline and loads the register reset values.
// ----------------------------------------------------------------------------
module coupled_joint_polynomial_map_core
    import cjpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_we,
    input  logic [INDEX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,

    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic signed [VALUE_W-1:0] master_angle,
    input  logic signed [VALUE_W-1:0] master_velocity,

    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic signed [VALUE_W-1:0] slave_value,
    output logic                      saturated
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_init <= '0;
            cfg_reg.master_min  <= VALUE_MIN;
            cfg_reg.master_max  <= VALUE_MAX;
            cfg_reg.slave_init  <= '0;
            cfg_reg.slave_min   <= VALUE_MIN;
            cfg_reg.slave_max   <= VALUE_MAX;
            cfg_reg.coeff_count <= COUNT_W'(1);
            cfg_reg.coeff_pack  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MASTER_INIT: cfg_reg.master_init <= cfg_data[VALUE_W-1:0];
                REG_MASTER_MIN:  cfg_reg.master_min  <= cfg_data[VALUE_W-1:0];
                REG_MASTER_MAX:  cfg_reg.master_max  <= cfg_data[VALUE_W-1:0];
                REG_SLAVE_INIT:  cfg_reg.slave_init  <= cfg_data[VALUE_W-1:0];
                REG_SLAVE_MIN:   cfg_reg.slave_min   <= cfg_data[VALUE_W-1:0];
                REG_SLAVE_MAX:   cfg_reg.slave_max   <= cfg_data[VALUE_W-1:0];
                REG_COEFF_COUNT: cfg_reg.coeff_count <= cfg_data[COUNT_W-1:0];
                REG_COEFF_PACK:  cfg_reg.coeff_pack  <= cfg_data[PACK_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front stage and cell chain. Position 0 is the front stage output,
    // position CELL_COUNT the end of the chain.
    // ------------------------------------------------------------------
    logic   valid_chain [CELL_COUNT+1];
    logic   ready_chain [CELL_COUNT+1];
    token_t tok_chain   [CELL_COUNT+1];

    cjpm_prep u_prep (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (req_valid),
        .in_ready        (req_ready),
        .req_type        (req_type),
        .master_angle    (master_angle),
        .master_velocity (master_velocity),
        .out_valid       (valid_chain[0]),
        .out_ready       (ready_chain[0]),
        .out_tok         (tok_chain[0])
    );

    // Cells 0..CELL_COUNT-2 run the Horner steps, the last one applies
    // the closing multiply (or bypass) against the slave base.
    for (genvar c = 0; c < CELL_COUNT; c++)
    begin : g_cell
        cjpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_chain[c]),
            .in_ready  (ready_chain[c]),
            .in_tok    (tok_chain[c]),
            .out_valid (valid_chain[c+1]),
            .out_ready (ready_chain[c+1]),
            .out_tok   (tok_chain[c+1])
        );
    end

    // ------------------------------------------------------------------
    // Final 16-bit clamp and output register
    // ------------------------------------------------------------------
    logic                      rsp_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      sat_reg;
    logic                      sat_next;
    logic signed [WIDE_W-1:0]  final_acc;
    logic                      final_fits;

    assign final_acc  = tok_chain[CELL_COUNT].acc;
    assign final_fits = (final_acc[WIDE_W-1:VALUE_W-1]
                         == {(WIDE_W-VALUE_W+1){final_acc[WIDE_W-1]}});

    always_comb
    begin
        if (final_fits)
        begin
            value_next = final_acc[VALUE_W-1:0];
        end
        else
        begin
            value_next = final_acc[WIDE_W-1] ? VALUE_MIN : VALUE_MAX;
        end
        sat_next = tok_chain[CELL_COUNT].sat || !final_fits;
    end

    assign ready_chain[CELL_COUNT] = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ready_chain[CELL_COUNT])
        begin
            rsp_valid_reg <= valid_chain[CELL_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_chain[CELL_COUNT] && ready_chain[CELL_COUNT])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign slave_value = value_reg;
    assign saturated   = sat_reg;

    rsp_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(valid_chain[CELL_COUNT]))
        else $error("response appeared without a chain result");

    req_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> valid_chain[0])
        else $error("accepted request missing from front stage");

endmodule
